### rtl/stroke_segment_line_hit_test_macros.svh
// assertion macros shared by the stroke segment hit test rtl
// no dependencies; included by the modules that carry assertions
`ifndef STROKE_SEGMENT_LINE_HIT_TEST_MACROS_SVH
`define STROKE_SEGMENT_LINE_HIT_TEST_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSLHT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSLHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sslht_pkg.sv
// shared types and constants of the stroke segment hit test
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sslht_pkg;

    // configuration register map
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    localparam t_cfg_index CFG_LINE_START_X = 2'd0;
    localparam t_cfg_index CFG_LINE_START_Y = 2'd1;
    localparam t_cfg_index CFG_LINE_END_X   = 2'd2;
    localparam t_cfg_index CFG_LINE_END_Y   = 2'd3;

    // per-item control that travels down the pipeline
    typedef struct packed {
        logic seg_ok;   // a segment ends at this point (stroke already open)
        logic last;     // last point of the stroke
    } t_sslht_ctrl;

endpackage

`default_nettype wire

### rtl/sslht_point_if.sv
// stroke point and hit result channels (valid/ready with payload)
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface sslht_point_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          first_point;
    logic                          last_point;

    modport source (output valid, point_x, point_y, first_point, last_point, input ready);
    modport sink   (input valid, point_x, point_y, first_point, last_point, output ready);
endinterface

interface sslht_result_if;
    logic valid;
    logic ready;
    logic segment_hit;
    logic stroke_hit;
    logic stroke_end;

    modport source (output valid, segment_hit, stroke_hit, stroke_end, input ready);
    modport sink   (input valid, segment_hit, stroke_hit, stroke_end, output ready);
endinterface

`default_nettype wire

### rtl/sslht_front.sv
// input stage: takes a point, keeps the previous point, registers the differences
// depends on sslht_pkg and sslht_point_if
`timescale 1ns / 1ps
`default_nettype none
`include "stroke_segment_line_hit_test_macros.svh"

module sslht_front #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    sslht_point_if.sink                            i_point,
    input  wire logic signed [COORD_WIDTH-1:0]     i_line_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_line_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_line_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_line_end_y,
    input  wire logic                              i_ready_dn,
    output logic                                   o_valid,
    output logic signed [COORD_WIDTH:0]            o_rx,
    output logic signed [COORD_WIDTH:0]            o_ry,
    output logic signed [COORD_WIDTH:0]            o_sx,
    output logic signed [COORD_WIDTH:0]            o_sy,
    output logic signed [COORD_WIDTH:0]            o_qx,
    output logic signed [COORD_WIDTH:0]            o_qy,
    output sslht_pkg::t_sslht_ctrl                 o_ctrl
);
    import sslht_pkg::*;

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;

    logic                          r_valid;
    logic signed [COORD_WIDTH-1:0] r_prev_x;
    logic signed [COORD_WIDTH-1:0] r_prev_y;
    logic                          r_have_prev;
    logic signed [DIFF_WIDTH-1:0]  r_rx, r_ry, r_sx, r_sy, r_qx, r_qy;
    t_sslht_ctrl                   r_ctrl;

    logic                          acc;
    logic signed [DIFF_WIDTH-1:0]  cx, cy, px, py, s0x, s0y, e0x, e0y;
    t_sslht_ctrl                   n_ctrl;

    assign i_point.ready = !r_valid || i_ready_dn;
    assign acc           = i_point.valid && i_point.ready;

    // sign-extend by one bit so every difference is exact
    assign cx  = {i_point.point_x[COORD_WIDTH-1], i_point.point_x};
    assign cy  = {i_point.point_y[COORD_WIDTH-1], i_point.point_y};
    assign px  = {r_prev_x[COORD_WIDTH-1], r_prev_x};
    assign py  = {r_prev_y[COORD_WIDTH-1], r_prev_y};
    assign s0x = {i_line_start_x[COORD_WIDTH-1], i_line_start_x};
    assign s0y = {i_line_start_y[COORD_WIDTH-1], i_line_start_y};
    assign e0x = {i_line_end_x[COORD_WIDTH-1], i_line_end_x};
    assign e0y = {i_line_end_y[COORD_WIDTH-1], i_line_end_y};

    always_comb begin
        n_ctrl.seg_ok = r_have_prev && !i_point.first_point;
        n_ctrl.last   = i_point.last_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            if (i_point.ready) begin
                r_valid <= i_point.valid;
            end
            if (acc) begin
                r_prev_x    <= i_point.point_x;
                r_prev_y    <= i_point.point_y;
                r_have_prev <= !i_point.last_point;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rx   <= cx - px;
            r_ry   <= cy - py;
            r_sx   <= e0x - s0x;
            r_sy   <= e0y - s0y;
            r_qx   <= s0x - px;
            r_qy   <= s0y - py;
            r_ctrl <= n_ctrl;
        end
    end

    assign o_valid = r_valid;
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_ctrl  = r_ctrl;

    `SSLHT_ASSERT_NEXT(a_last_closes_stroke, i_clk, i_rst_n, acc && i_point.last_point, !r_have_prev, "last point left stroke open")

endmodule

`default_nettype wire

### rtl/sslht_cross.sv
// cross product stage: three 2-d cross products, registered
// depends on sslht_pkg
`timescale 1ns / 1ps
`default_nettype none

module sslht_cross #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [COORD_WIDTH:0]       i_rx,
    input  wire logic signed [COORD_WIDTH:0]       i_ry,
    input  wire logic signed [COORD_WIDTH:0]       i_sx,
    input  wire logic signed [COORD_WIDTH:0]       i_sy,
    input  wire logic signed [COORD_WIDTH:0]       i_qx,
    input  wire logic signed [COORD_WIDTH:0]       i_qy,
    input  wire sslht_pkg::t_sslht_ctrl            i_ctrl,
    input  wire logic                              i_ready_dn,
    output logic                                   o_ready_up,
    output logic                                   o_valid,
    output logic signed [2*COORD_WIDTH+2:0]        o_rs,
    output logic signed [2*COORD_WIDTH+2:0]        o_qs,
    output logic signed [2*COORD_WIDTH+2:0]        o_qr,
    output sslht_pkg::t_sslht_ctrl                 o_ctrl
);
    import sslht_pkg::*;

    localparam int PROD_WIDTH  = 2 * (COORD_WIDTH + 1);
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;

    logic                          r_valid;
    logic signed [CROSS_WIDTH-1:0] r_rs, r_qs, r_qr;
    t_sslht_ctrl                   r_ctrl;

    logic signed [PROD_WIDTH-1:0]  p_rx_sy, p_ry_sx, p_qx_sy, p_qy_sx, p_qx_ry, p_qy_rx;
    logic signed [CROSS_WIDTH-1:0] n_rs, n_qs, n_qr;
    logic                          load;

    assign o_ready_up = !r_valid || i_ready_dn;
    assign load       = i_valid && o_ready_up;

    // operands sign-extended to the product width; the upper halves are sign copies
    assign p_rx_sy = PROD_WIDTH'(i_rx) * PROD_WIDTH'(i_sy);
    assign p_ry_sx = PROD_WIDTH'(i_ry) * PROD_WIDTH'(i_sx);
    assign p_qx_sy = PROD_WIDTH'(i_qx) * PROD_WIDTH'(i_sy);
    assign p_qy_sx = PROD_WIDTH'(i_qy) * PROD_WIDTH'(i_sx);
    assign p_qx_ry = PROD_WIDTH'(i_qx) * PROD_WIDTH'(i_ry);
    assign p_qy_rx = PROD_WIDTH'(i_qy) * PROD_WIDTH'(i_rx);

    // one guard bit keeps the difference of two products exact
    assign n_rs = {p_rx_sy[PROD_WIDTH-1], p_rx_sy} - {p_ry_sx[PROD_WIDTH-1], p_ry_sx};
    assign n_qs = {p_qx_sy[PROD_WIDTH-1], p_qx_sy} - {p_qy_sx[PROD_WIDTH-1], p_qy_sx};
    assign n_qr = {p_qx_ry[PROD_WIDTH-1], p_qx_ry} - {p_qy_rx[PROD_WIDTH-1], p_qy_rx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs   <= n_rs;
            r_qs   <= n_qs;
            r_qr   <= n_qr;
            r_ctrl <= i_ctrl;
        end
    end

    assign o_valid = r_valid;
    assign o_rs    = r_rs;
    assign o_qs    = r_qs;
    assign o_qr    = r_qr;
    assign o_ctrl  = r_ctrl;

endmodule

`default_nettype wire

### rtl/sslht_decide.sv
// decision stage: range checks on the cross products, stroke flag, result register
// depends on sslht_pkg and sslht_result_if
`timescale 1ns / 1ps
`default_nettype none
`include "stroke_segment_line_hit_test_macros.svh"

module sslht_decide #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [2*COORD_WIDTH+2:0]   i_rs,
    input  wire logic signed [2*COORD_WIDTH+2:0]   i_qs,
    input  wire logic signed [2*COORD_WIDTH+2:0]   i_qr,
    input  wire sslht_pkg::t_sslht_ctrl            i_ctrl,
    output logic                                   o_ready_up,
    sslht_result_if.source                         o_result
);
    import sslht_pkg::*;

    localparam int CROSS_WIDTH = 2 * COORD_WIDTH + 3;

    logic r_valid;
    logic r_sticky;
    logic r_segment_hit;
    logic r_stroke_hit;
    logic r_stroke_end;

    logic load;
    logic rs_zero, rs_neg;
    logic qs_zero, qs_neg, qr_zero, qr_neg;
    logic hit_pos, hit_neg, hit;
    logic n_segment_hit, n_sticky;

    assign o_ready_up = !r_valid || o_result.ready;
    assign load       = i_valid && o_ready_up;

    assign rs_zero = (i_rs == '0);
    assign rs_neg  = i_rs[CROSS_WIDTH-1];
    assign qs_zero = (i_qs == '0);
    assign qs_neg  = i_qs[CROSS_WIDTH-1];
    assign qr_zero = (i_qr == '0);
    assign qr_neg  = i_qr[CROSS_WIDTH-1];

    // both parameters in 0..1: numerators share the sign of rs and do not exceed it
    assign hit_pos = !qs_neg && (i_qs <= i_rs) && !qr_neg && (i_qr <= i_rs);
    assign hit_neg = (qs_neg || qs_zero) && (i_qs >= i_rs)
                  && (qr_neg || qr_zero) && (i_qr >= i_rs);
    assign hit     = !rs_zero && (rs_neg ? hit_neg : hit_pos);

    assign n_segment_hit = i_ctrl.seg_ok && hit;
    assign n_sticky      = i_ctrl.seg_ok ? (r_sticky || hit) : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_sticky <= 1'b0;
        end else begin
            if (o_ready_up) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_sticky <= n_sticky;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_segment_hit <= n_segment_hit;
            r_stroke_hit  <= n_sticky;
            r_stroke_end  <= i_ctrl.last;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.segment_hit = r_segment_hit;
    assign o_result.stroke_hit  = r_stroke_hit;
    assign o_result.stroke_end  = r_stroke_end;

    `SSLHT_ASSERT_IMPLIES(a_seg_sets_stroke, i_clk, i_rst_n, o_result.valid && o_result.segment_hit, o_result.stroke_hit, "segment hit without stroke hit")
    `SSLHT_ASSERT_NEXT(a_new_stroke_clear, i_clk, i_rst_n, load && !i_ctrl.seg_ok, !o_result.segment_hit && !o_result.stroke_hit && !r_sticky, "new stroke not cleared")

endmodule

`default_nettype wire

### rtl/stroke_segment_line_hit_test.sv
// top level of the stroke segment hit test: configuration registers and pipeline
// depends on sslht_pkg, sslht_point_if, sslht_front, sslht_cross, sslht_decide
`timescale 1ns / 1ps
`default_nettype none
`include "stroke_segment_line_hit_test_macros.svh"

// usage
//   i_point carries stroke points (x, y, first/last markers) with valid/ready;
//   one transfer per point. o_result gives one transfer per point: segment_hit
//   for the segment from the previous point, stroke_hit (sticky over the
//   stroke) and stroke_end (echo of last_point, stroke_hit is then final).
//   the eraser segment sits in four registers written over i_cfg_we /
//   i_cfg_index / i_cfg_data while no point is in flight.
// timing
//   three register stages: input/differences, cross products, decision.
//   an accepted point moves through the cross product and decision registers
//   to the result; with the output free one point is taken every cycle. the
//   product stage (six signed (COORD_WIDTH+1)-bit multipliers) sets the clock.
// reset and stall
//   synchronous active-low reset empties the pipeline, clears the stroke
//   state and sets the eraser segment to all zero.
//   each stage holds while the next is full and stalled, so i_point.ready
//   drops only once every stage holds a result and o_result.ready is low.
module stroke_segment_line_hit_test #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    sslht_point_if.sink                               i_point,
    sslht_result_if.source                            o_result,
    input  wire logic                                 i_cfg_we,
    input  wire sslht_pkg::t_cfg_index                i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]               i_cfg_data
);
    import sslht_pkg::*;

    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int CROSS_WIDTH = 2 * COORD_WIDTH + 3;

    // eraser segment registers
    logic signed [COORD_WIDTH-1:0] r_line_start_x;
    logic signed [COORD_WIDTH-1:0] r_line_start_y;
    logic signed [COORD_WIDTH-1:0] r_line_end_x;
    logic signed [COORD_WIDTH-1:0] r_line_end_y;

    // front -> cross
    logic                          f_valid;
    logic signed [DIFF_WIDTH-1:0]  f_rx, f_ry, f_sx, f_sy, f_qx, f_qy;
    t_sslht_ctrl                   f_ctrl;
    logic                          c_ready;

    // cross -> decide
    logic                          c_valid;
    logic signed [CROSS_WIDTH-1:0] c_rs, c_qs, c_qr;
    t_sslht_ctrl                   c_ctrl;
    logic                          d_ready;

    // configuration writes, to be made only while the pipeline is idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_start_x <= '0;
            r_line_start_y <= '0;
            r_line_end_x   <= '0;
            r_line_end_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_START_X: r_line_start_x <= i_cfg_data;
                CFG_LINE_START_Y: r_line_start_y <= i_cfg_data;
                CFG_LINE_END_X:   r_line_end_x   <= i_cfg_data;
                CFG_LINE_END_Y:   r_line_end_y   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage 1: point capture, previous point, differences
    sslht_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_point        (i_point),
        .i_line_start_x (r_line_start_x),
        .i_line_start_y (r_line_start_y),
        .i_line_end_x   (r_line_end_x),
        .i_line_end_y   (r_line_end_y),
        .i_ready_dn     (c_ready),
        .o_valid        (f_valid),
        .o_rx           (f_rx),
        .o_ry           (f_ry),
        .o_sx           (f_sx),
        .o_sy           (f_sy),
        .o_qx           (f_qx),
        .o_qy           (f_qy),
        .o_ctrl         (f_ctrl)
    );

    // stage 2: cross products
    sslht_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .i_rx       (f_rx),
        .i_ry       (f_ry),
        .i_sx       (f_sx),
        .i_sy       (f_sy),
        .i_qx       (f_qx),
        .i_qy       (f_qy),
        .i_ctrl     (f_ctrl),
        .i_ready_dn (d_ready),
        .o_ready_up (c_ready),
        .o_valid    (c_valid),
        .o_rs       (c_rs),
        .o_qs       (c_qs),
        .o_qr       (c_qr),
        .o_ctrl     (c_ctrl)
    );

    // stage 3: range checks, stroke flag, result register
    sslht_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (c_valid),
        .i_rs       (c_rs),
        .i_qs       (c_qs),
        .i_qr       (c_qr),
        .i_ctrl     (c_ctrl),
        .o_ready_up (d_ready),
        .o_result   (o_result)
    );

    // an empty output register means no stage can be blocked
    `SSLHT_ASSERT_IMPLIES(a_ready_when_out_empty, i_clk, i_rst_n, !o_result.valid, i_point.ready, "input blocked with empty output")

endmodule

`default_nettype wire

### test/tb.sv
// self-checking testbench for the stroke segment hit test
// depends on sslht_pkg, sslht_point_if, sslht_result_if and stroke_segment_line_hit_test
`timescale 1ns / 1ps

module tb;
    import sslht_pkg::*;

    localparam int CW = 16;
    // cycles with no transfer on either channel before the run is declared hung
    localparam int STALL_LIMIT = 4000;

    typedef logic signed [CW-1:0] t_coord;

    // one hit result as seen on the output channel
    typedef struct packed {
        logic seg_hit;
        logic stroke_hit;
        logic stroke_end;
    } t_hit_result;

    // scoreboard: predicts the hit result of every accepted point
    // and compares it with what comes out, in order
    class hit_scoreboard;
        longint      eraser [4];
        longint      prev_x;
        longint      prev_y;
        bit          open_stroke;
        bit          sticky_hit;
        t_hit_result pending_q [$];
        int          mismatches;
        int          points_seen;
        int          results_seen;
        int          seg_hits;
        int          strokes_done;

        function void write_reg(t_cfg_index idx, t_coord v);
            eraser[idx] = longint'(v);
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // exact cross-product test of segment prev->cur against the eraser
        function bit crosses_eraser(longint cx, longint cy);
            longint rx, ry, sx, sy, qx, qy, rs, qs, qr;
            rx = cx - prev_x;
            ry = cy - prev_y;
            sx = eraser[CFG_LINE_END_X] - eraser[CFG_LINE_START_X];
            sy = eraser[CFG_LINE_END_Y] - eraser[CFG_LINE_START_Y];
            qx = eraser[CFG_LINE_START_X] - prev_x;
            qy = eraser[CFG_LINE_START_Y] - prev_y;
            rs = rx * sy - ry * sx;
            qs = qx * sy - qy * sx;
            qr = qx * ry - qy * rx;
            // parallel, collinear or zero-length: never a hit
            if (rs == 0)
                return 1'b0;
            if (rs < 0) begin
                rs = -rs;
                qs = -qs;
                qr = -qr;
            end
            return (qs >= 0) && (qs <= rs) && (qr >= 0) && (qr <= rs);
        endfunction

        function void note_point(t_coord x, t_coord y, logic first, logic last);
            t_hit_result r;
            r.seg_hit = 1'b0;
            if (first || !open_stroke) begin
                sticky_hit = 1'b0;
            end else begin
                r.seg_hit = crosses_eraser(longint'(x), longint'(y));
                if (r.seg_hit)
                    sticky_hit = 1'b1;
            end
            prev_x      = longint'(x);
            prev_y      = longint'(y);
            open_stroke = !last;
            r.stroke_hit = sticky_hit;
            r.stroke_end = last;
            pending_q.push_back(r);
            points_seen++;
        endfunction

        function void check_result(t_hit_result got);
            t_hit_result want;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: seg=%b stroke=%b end=%b",
                             $time, got.seg_hit, got.stroke_hit, got.stroke_end);
                return;
            end
            want = pending_q.pop_front();
            if (got.seg_hit) seg_hits++;
            if (got.stroke_end) strokes_done++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: hit result mismatch: expected seg=%b stroke=%b end=%b, got seg=%b stroke=%b end=%b",
                             $time, want.seg_hit, want.stroke_hit, want.stroke_end,
                             got.seg_hit, got.stroke_hit, got.stroke_end);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    t_cfg_index cfg_index;
    logic [CW-1:0] cfg_data;

    sslht_point_if #(.COORD_WIDTH(CW)) point_ch ();
    sslht_result_if                    result_ch ();

    stroke_segment_line_hit_test #(
        .COORD_WIDTH(CW)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_point     (point_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hit_scoreboard sb = new();

    // idle percentages of the current phase, and the long receiver hold-off
    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;
    int eraser_settings;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, or held off entirely during the pressure phase
    always @(negedge i_clk) begin
        if (recv_hold)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // input monitor: every point transfer feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && point_ch.valid && point_ch.ready)
            sb.note_point(point_ch.point_x, point_ch.point_y,
                          point_ch.first_point, point_ch.last_point);
    end

    // output monitor: every result transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check_result({result_ch.segment_hit, result_ch.stroke_hit,
                             result_ch.stroke_end});
    end

    // watchdog: too long without any transfer means the block hung
    always @(posedge i_clk) begin
        if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one point, idling first at random; returns on the falling edge after transfer
    task automatic send_point(input t_coord x, input t_coord y,
                              input logic first, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            point_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        point_ch.valid       <= 1'b1;
        point_ch.point_x     <= x;
        point_ch.point_y     <= y;
        point_ch.first_point <= first;
        point_ch.last_point  <= last;
        do
            @(posedge i_clk);
        while (!point_ch.ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every prediction has been matched
    task automatic drain();
        point_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        // pipeline is three stages deep
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_coord v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.write_reg(idx, v);
        @(negedge i_clk);
    endtask

    // load a new eraser segment; only called with the pipeline empty
    task automatic set_eraser(input t_coord sx, input t_coord sy,
                              input t_coord ex, input t_coord ey);
        write_reg(CFG_LINE_START_X, sx);
        write_reg(CFG_LINE_START_Y, sy);
        write_reg(CFG_LINE_END_X, ex);
        write_reg(CFG_LINE_END_Y, ey);
        cfg_we <= 1'b0;
        eraser_settings++;
    endtask

    // coordinate near the eraser's span on one axis, now and then anywhere
    function automatic t_coord pick_coord(input longint a, input longint b);
        longint lo, hi;
        if ($urandom_range(99) < 20)
            return t_coord'($urandom());
        lo = ((a < b) ? a : b) - 64;
        hi = ((a < b) ? b : a) + 64;
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        return t_coord'(lo + longint'($urandom_range(int'(hi - lo))));
    endfunction

    // mostly well-formed strokes with random points, some noise and broken markers
    task automatic run_strokes(input int n_points);
        int   sent;
        int   len;
        logic first;
        logic last;
        sent = 0;
        while (sent < n_points) begin
            if ($urandom_range(99) < 10) begin
                // stray point with random markers
                send_point(t_coord'($urandom()), t_coord'($urandom()),
                           1'($urandom()), 1'($urandom()));
                sent++;
            end else begin
                len = $urandom_range(8, 1);
                for (int k = 0; k < len; k++) begin
                    first = (k == 0);
                    last  = (k == len - 1);
                    // occasionally break the stroke framing
                    if ($urandom_range(99) < 5) first = ~first;
                    if ($urandom_range(99) < 5) last = ~last;
                    send_point(pick_coord(sb.eraser[CFG_LINE_START_X], sb.eraser[CFG_LINE_END_X]),
                               pick_coord(sb.eraser[CFG_LINE_START_Y], sb.eraser[CFG_LINE_END_Y]),
                               first, last);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_LINE_START_X;
        cfg_data             = '0;
        point_ch.valid       = 1'b0;
        point_ch.point_x     = '0;
        point_ch.point_y     = '0;
        point_ch.first_point = 1'b0;
        point_ch.last_point  = 1'b0;
        result_ch.ready      = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        recv_hold            = 1'b0;
        eraser_settings      = 0;
        idle_cycles          = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset eraser is a single point at the origin: degenerate, never hit
        send_point(16'sd0, -16'sd10, 1'b1, 1'b0);
        send_point(16'sd0, 16'sd10, 1'b0, 1'b1);
        drain();

        set_eraser(-16'sd100, 16'sd0, 16'sd100, 16'sd0);
        // single-point stroke
        send_point(16'sd0, 16'sd0, 1'b1, 1'b1);
        // clean crossing, then sticky flag holds through the rest of the stroke
        send_point(16'sd0, -16'sd50, 1'b1, 1'b0);
        send_point(16'sd0, 16'sd50, 1'b0, 1'b0);
        send_point(16'sd10, 16'sd60, 1'b0, 1'b0);
        send_point(16'sd20, 16'sd70, 1'b0, 1'b1);
        // point after a stroke end opens a new stroke without the first marker
        send_point(-16'sd300, 16'sd5, 1'b0, 1'b0);
        // collinear overlap, parallel, then zero-length segment
        send_point(16'sd300, 16'sd0, 1'b0, 1'b0);
        send_point(-16'sd300, 16'sd0, 1'b0, 1'b0);
        send_point(-16'sd300, 16'sd10, 1'b0, 1'b0);
        send_point(16'sd300, 16'sd10, 1'b0, 1'b0);
        send_point(16'sd300, 16'sd10, 1'b0, 1'b0);
        // touching the eraser end point, and ending exactly on the eraser
        send_point(16'sd100, -16'sd10, 1'b0, 1'b0);
        send_point(16'sd100, 16'sd10, 1'b0, 1'b0);
        send_point(16'sd0, -16'sd10, 1'b1, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
        // just past the eraser end: miss; first marker mid-stroke clears the flag
        send_point(16'sd101, -16'sd10, 1'b1, 1'b0);
        send_point(16'sd101, 16'sd10, 1'b0, 1'b0);
        send_point(16'sd0, -16'sd10, 1'b1, 1'b1);
        drain();

        // full-range diagonals crossing at the middle
        set_eraser(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 1'b0, 1'b1);
        drain();

        // random phases: eraser settings cycling through the idle patterns
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_eraser(-16'sd1000, -16'sd500, 16'sd1200, 16'sd800);
                1: set_eraser(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
                2: set_eraser(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
                3: set_eraser(16'sd5, 16'sd5, 16'sd5, 16'sd5);
                4: set_eraser(16'sd20, -16'sd30, 16'sd20, 16'sd30);
                5: set_eraser(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
                default: set_eraser(t_coord'($urandom()), t_coord'($urandom()),
                                    t_coord'($urandom()), t_coord'($urandom()));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            run_strokes(65);
            drain();
        end

        // back pressure: receiver held off while points keep coming, so the block fills
        set_eraser(-16'sd2000, 16'sd1500, 16'sd2500, -16'sd1000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (80) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            run_strokes(40);
        join
        drain();
        repeat (10) @(negedge i_clk);

        $display("run covered %0d points and %0d results over %0d eraser settings",
                 sb.points_seen, sb.results_seen, eraser_settings);
        $display("%0d segment hits, %0d stroke ends, %0d mismatches, %0d results outstanding",
                 sb.seg_hits, sb.strokes_done, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sslht_pkg.sv
rtl/sslht_point_if.sv
rtl/sslht_front.sv
rtl/sslht_cross.sv
rtl/sslht_decide.sv
rtl/stroke_segment_line_hit_test.sv
test/tb.sv
